// ===== rtl/core/mpr_pkg.sv =====
// Shared widths, codes, reset values and types of the microphone pickup response block.
package mpr_pkg;

  localparam int POS_W      = 24;
  localparam int DIFF_W     = 25;
  localparam int FACE_W     = 16;
  localparam int INV_W      = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int R2_W       = 50;
  localparam int DOT_W      = 43;
  localparam int NUM_W      = 49;
  localparam int SQ_V_W     = 62;
  localparam int ROOT_W     = 31;
  localparam int SQ_REM_W   = 33;
  localparam int AQ_W       = 49;
  localparam int ACAP_W     = 47;
  localparam int KQ_W       = 18;
  localparam int FMAG_W     = 18;
  localparam int PROD_W     = 65;
  localparam int DFULL_W    = 55;
  localparam int AMAG_W     = 51;
  localparam int DELAY_W    = 32;
  localparam int AMP_W      = 32;

  localparam int SQ_STEPS    = 31;
  localparam int AQ_STEPS    = 49;
  localparam int KQ_STEPS    = 18;
  localparam int K_START     = 31;
  localparam int PIPE_STAGES = 49;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [MODE_W-1:0] MODE_OMNI = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIG8 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CARD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_Z = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV    = 3'd7;

  localparam logic signed [FACE_W-1:0] FACE_Z_RST = 16'sd16384;
  localparam logic [INV_W-1:0]         INV_RST    = 24'd48913;

  localparam logic [KQ_W-1:0]   K_CAP      = 18'd131072;
  localparam logic [KQ_W-1:0]   K_ONE      = 18'd16384;
  localparam logic [AQ_W-1:0]   A_CAP      = 49'h4000_0000_0000;
  localparam logic [AMAG_W-1:0] AMP_POS_MAX = 51'h7FFF_FFFF;
  localparam logic [AMAG_W-1:0] AMP_NEG_MAX = 51'h8000_0000;
  localparam logic [DELAY_W-1:0] DELAY_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [MODE_W-1:0]        pickup_mode;
    logic signed [POS_W-1:0]  mic_pos_x;
    logic signed [POS_W-1:0]  mic_pos_y;
    logic signed [POS_W-1:0]  mic_pos_z;
    logic signed [FACE_W-1:0] facing_x;
    logic signed [FACE_W-1:0] facing_y;
    logic signed [FACE_W-1:0] facing_z;
    logic [INV_W-1:0]         inv_speed;
  } cfg_t;

  typedef struct packed {
    logic [R2_W-1:0]  r2;
    logic             neg;
    logic [DOT_W-1:0] dmag;
  } entry_t;

  typedef struct packed {
    logic [R2_W-1:0]     r2;
    logic                neg;
    logic [NUM_W-1:0]    nmag;
    logic [SQ_REM_W-1:0] sq_rem;
    logic [ROOT_W-1:0]   sq_root;
    logic [R2_W-1:0]     a_rem;
    logic [AQ_W-1:0]     a_quo;
    logic [ROOT_W-1:0]   k_rem;
    logic [KQ_W-1:0]     k_quo;
    logic                k_sat;
  } stage_t;

endpackage

// ===== rtl/core/mpr_front.sv =====
// Front end: takes source positions and forms squared distance and facing dot product.
module mpr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpr_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [mpr_pkg::POS_W-1:0] in_src_x,
  input  logic signed [mpr_pkg::POS_W-1:0] in_src_y,
  input  logic signed [mpr_pkg::POS_W-1:0] in_src_z,
  input  logic                           q_full,
  output logic                           q_push,
  output mpr_pkg::entry_t                q_data
);

  logic                               valid_r;
  logic signed [mpr_pkg::POS_W-1:0]   src_x_r, src_y_r, src_z_r;
  logic signed [mpr_pkg::DIFF_W-1:0]  dx, dy, dz;
  logic [mpr_pkg::DIFF_W-1:0]         mx, my, mz;
  logic signed [mpr_pkg::DOT_W-1:0]   px, py, pz, dot;

  assign q_push   = valid_r && !q_full;
  assign in_ready = !valid_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      src_x_r <= in_src_x;
      src_y_r <= in_src_y;
      src_z_r <= in_src_z;
    end
  end

  always_comb begin
    dx = mpr_pkg::DIFF_W'(src_x_r) - mpr_pkg::DIFF_W'(cfg.mic_pos_x);
    dy = mpr_pkg::DIFF_W'(src_y_r) - mpr_pkg::DIFF_W'(cfg.mic_pos_y);
    dz = mpr_pkg::DIFF_W'(src_z_r) - mpr_pkg::DIFF_W'(cfg.mic_pos_z);
    mx = dx[mpr_pkg::DIFF_W-1] ? mpr_pkg::DIFF_W'(-dx) : mpr_pkg::DIFF_W'(dx);
    my = dy[mpr_pkg::DIFF_W-1] ? mpr_pkg::DIFF_W'(-dy) : mpr_pkg::DIFF_W'(dy);
    mz = dz[mpr_pkg::DIFF_W-1] ? mpr_pkg::DIFF_W'(-dz) : mpr_pkg::DIFF_W'(dz);
    px = mpr_pkg::DOT_W'(cfg.facing_x) * mpr_pkg::DOT_W'(dx);
    py = mpr_pkg::DOT_W'(cfg.facing_y) * mpr_pkg::DOT_W'(dy);
    pz = mpr_pkg::DOT_W'(cfg.facing_z) * mpr_pkg::DOT_W'(dz);
    dot = px + py + pz;
    q_data.r2 = mpr_pkg::R2_W'(mx) * mpr_pkg::R2_W'(mx)
              + mpr_pkg::R2_W'(my) * mpr_pkg::R2_W'(my)
              + mpr_pkg::R2_W'(mz) * mpr_pkg::R2_W'(mz);
    q_data.neg  = dot[mpr_pkg::DOT_W-1];
    q_data.dmag = dot[mpr_pkg::DOT_W-1] ? mpr_pkg::DOT_W'(-dot) : mpr_pkg::DOT_W'(dot);
  end

endmodule

// ===== rtl/core/mpr_queue.sv =====
// Short item queue between the front end and the arithmetic back end.
module mpr_queue #(
  parameter int DEPTH = mpr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mpr_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output mpr_pkg::entry_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mpr_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/mpr_back.sv =====
// Back end: square root, reciprocal and cosine division stages, scaling and saturation.
module mpr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mpr_pkg::cfg_t                     cfg,
  input  logic                              q_valid,
  input  mpr_pkg::entry_t                   q_data,
  output logic                              q_pop,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [mpr_pkg::DELAY_W-1:0]       out_delay,
  output logic signed [mpr_pkg::AMP_W-1:0]  out_amplitude,
  output logic                              out_zero_distance,
  output logic                              out_saturated
);

  localparam int NST = mpr_pkg::PIPE_STAGES;

  logic             en;
  mpr_pkg::stage_t  init;
  mpr_pkg::stage_t  nxt  [NST];
  mpr_pkg::stage_t  ps_r [NST];
  logic [NST-1:0]   pv_r;

  logic                         mv_r;
  logic [mpr_pkg::DFULL_W-1:0]  dfull_r;
  logic [mpr_pkg::PROD_W-1:0]   prod_r;
  logic [mpr_pkg::AQ_W-1:0]     a_r;
  logic                         scaled_r, sh15_r, fneg_r, zero_r;

  logic [mpr_pkg::KQ_W-1:0]     kmag;
  logic [mpr_pkg::FMAG_W-1:0]   fmag;
  logic                         fneg, scaled, sh15;
  logic [mpr_pkg::ACAP_W-1:0]   acap;

  logic [mpr_pkg::AMAG_W-1:0]   amag;
  logic [mpr_pkg::DFULL_W-1:0]  dshift;
  logic [mpr_pkg::DELAY_W-1:0]  delay_c;
  logic [mpr_pkg::AMP_W-1:0]    amp_c;
  logic                         sat_c;

  logic                              out_valid_r;
  logic [mpr_pkg::DELAY_W-1:0]       out_delay_r;
  logic [mpr_pkg::AMP_W-1:0]         out_amp_r;
  logic                              out_zero_r, out_sat_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  always_comb begin
    init         = '0;
    init.r2      = q_data.r2;
    init.neg     = q_data.neg;
    init.nmag    = {q_data.dmag, 6'd0};
  end

  genvar s;
  for (s = 0; s < NST; s++) begin : g_stage
    localparam int SQI = (s < mpr_pkg::SQ_STEPS) ? mpr_pkg::SQ_STEPS - 1 - s : 0;
    localparam int KB  = (s >= mpr_pkg::K_START && s < mpr_pkg::K_START + mpr_pkg::KQ_STEPS)
                         ? mpr_pkg::KQ_STEPS - 1 - (s - mpr_pkg::K_START) : 0;
    mpr_pkg::stage_t p;
    logic            pv;

    if (s == 0) begin : g_first
      assign p  = init;
      assign pv = q_valid;
    end else begin : g_rest
      assign p  = ps_r[s-1];
      assign pv = pv_r[s-1];
    end

    always_comb begin
      logic [mpr_pkg::SQ_V_W-1:0]     sq_v;
      logic [mpr_pkg::SQ_REM_W+1:0]   sq_x;
      logic [mpr_pkg::SQ_REM_W+1:0]   sq_t;
      logic [mpr_pkg::R2_W:0]         a_x;
      logic [mpr_pkg::ROOT_W:0]       k_x;
      nxt[s] = p;
      sq_v = {p.r2, 12'd0};
      sq_x = {p.sq_rem, sq_v[2*SQI +: 2]};
      sq_t = {2'b00, p.sq_root, 2'b01};
      a_x  = {p.a_rem, (s == 0)};
      k_x  = (s == mpr_pkg::K_START) ? {p.nmag[mpr_pkg::NUM_W-1:mpr_pkg::KQ_W], p.nmag[KB]}
                                     : {p.k_rem, p.nmag[KB]};
      if (s < mpr_pkg::SQ_STEPS) begin
        if (sq_x >= sq_t) begin
          nxt[s].sq_rem  = mpr_pkg::SQ_REM_W'(sq_x - sq_t);
          nxt[s].sq_root = {p.sq_root[mpr_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          nxt[s].sq_rem  = mpr_pkg::SQ_REM_W'(sq_x);
          nxt[s].sq_root = {p.sq_root[mpr_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      if (s < mpr_pkg::AQ_STEPS) begin
        if (a_x >= {1'b0, p.r2}) begin
          nxt[s].a_rem = mpr_pkg::R2_W'(a_x - {1'b0, p.r2});
          nxt[s].a_quo = {p.a_quo[mpr_pkg::AQ_W-2:0], 1'b1};
        end else begin
          nxt[s].a_rem = mpr_pkg::R2_W'(a_x);
          nxt[s].a_quo = {p.a_quo[mpr_pkg::AQ_W-2:0], 1'b0};
        end
      end
      if (s >= mpr_pkg::K_START && s < mpr_pkg::K_START + mpr_pkg::KQ_STEPS) begin
        if (s == mpr_pkg::K_START) begin
          nxt[s].k_sat = (p.nmag[mpr_pkg::NUM_W-1:mpr_pkg::KQ_W] >= p.sq_root);
        end
        if (k_x >= {1'b0, p.sq_root}) begin
          nxt[s].k_rem = mpr_pkg::ROOT_W'(k_x - {1'b0, p.sq_root});
          nxt[s].k_quo = {p.k_quo[mpr_pkg::KQ_W-2:0], 1'b1};
        end else begin
          nxt[s].k_rem = mpr_pkg::ROOT_W'(k_x);
          nxt[s].k_quo = {p.k_quo[mpr_pkg::KQ_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[s] <= 1'b0;
      end else if (en) begin
        pv_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ps_r[s] <= nxt[s];
      end
    end
  end

  always_comb begin
    mpr_pkg::stage_t q;
    q    = ps_r[NST-1];
    kmag = (q.k_sat || q.k_quo > mpr_pkg::K_CAP) ? mpr_pkg::K_CAP : q.k_quo;
    acap = (q.a_quo > mpr_pkg::A_CAP) ? mpr_pkg::ACAP_W'(mpr_pkg::A_CAP)
                                      : mpr_pkg::ACAP_W'(q.a_quo);
    scaled = 1'b0;
    sh15   = 1'b0;
    fneg   = 1'b0;
    fmag   = kmag;
    if (cfg.pickup_mode == mpr_pkg::MODE_FIG8) begin
      scaled = 1'b1;
      fneg   = q.neg && (kmag != '0);
    end else if (cfg.pickup_mode == mpr_pkg::MODE_CARD) begin
      scaled = 1'b1;
      sh15   = 1'b1;
      if (!q.neg) begin
        fmag = kmag + mpr_pkg::K_ONE;
      end else if (kmag > mpr_pkg::K_ONE) begin
        fneg = 1'b1;
        fmag = kmag - mpr_pkg::K_ONE;
      end else begin
        fmag = mpr_pkg::K_ONE - kmag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= pv_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dfull_r  <= mpr_pkg::DFULL_W'(ps_r[NST-1].sq_root) * mpr_pkg::DFULL_W'(cfg.inv_speed);
      prod_r   <= mpr_pkg::PROD_W'(acap) * mpr_pkg::PROD_W'(fmag);
      a_r      <= ps_r[NST-1].a_quo;
      scaled_r <= scaled;
      sh15_r   <= sh15;
      fneg_r   <= fneg;
      zero_r   <= (ps_r[NST-1].r2 == '0);
    end
  end

  always_comb begin
    sat_c  = 1'b0;
    dshift = dfull_r >> 14;
    if (dshift > mpr_pkg::DFULL_W'(mpr_pkg::DELAY_MAX)) begin
      delay_c = mpr_pkg::DELAY_MAX;
      sat_c   = 1'b1;
    end else begin
      delay_c = dshift[mpr_pkg::DELAY_W-1:0];
    end
    if (!scaled_r) begin
      amag = mpr_pkg::AMAG_W'(a_r);
    end else if (sh15_r) begin
      amag = mpr_pkg::AMAG_W'(prod_r >> 15);
    end else begin
      amag = mpr_pkg::AMAG_W'(prod_r >> 14);
    end
    if (fneg_r) begin
      if (amag > mpr_pkg::AMP_NEG_MAX) begin
        amag  = mpr_pkg::AMP_NEG_MAX;
        sat_c = 1'b1;
      end
      amp_c = mpr_pkg::AMP_W'(-amag);
    end else begin
      if (amag > mpr_pkg::AMP_POS_MAX) begin
        amag  = mpr_pkg::AMP_POS_MAX;
        sat_c = 1'b1;
      end
      amp_c = amag[mpr_pkg::AMP_W-1:0];
    end
    if (zero_r) begin
      delay_c = '0;
      amp_c   = '0;
      sat_c   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_delay_r <= delay_c;
      out_amp_r   <= amp_c;
      out_zero_r  <= zero_r;
      out_sat_r   <= sat_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_delay         = out_delay_r;
  assign out_amplitude     = $signed(out_amp_r);
  assign out_zero_distance = out_zero_r;
  assign out_saturated     = out_sat_r;

endmodule

// ===== rtl/core/mic_pickup_response_unit.sv =====
// Top level of the microphone pickup response block: registers, front end, queue, back end.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_src_x, in_src_y, in_src_z
//   out      output     out_valid / out_ready  out_delay, out_amplitude,
//                                              out_zero_distance, out_saturated
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// One item is accepted per cycle while the queue has room to take it.
// The depth is set by the 49-step reciprocal of the squared distance, which runs beside
// the 31-step square root and the 18-step cosine division in one shared stage chain.
// Reset loads the register defaults and empties the queue and all stages.
// While a result is offered and out_ready is low the back end holds, and the queue takes up to four more items.
module mic_pickup_response_unit #(
  parameter int QDEPTH = mpr_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mpr_pkg::POS_W-1:0]      in_src_x,
  input  logic signed [mpr_pkg::POS_W-1:0]      in_src_y,
  input  logic signed [mpr_pkg::POS_W-1:0]      in_src_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mpr_pkg::DELAY_W-1:0]           out_delay,
  output logic signed [mpr_pkg::AMP_W-1:0]      out_amplitude,
  output logic                                  out_zero_distance,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  mpr_pkg::cfg_t   cfg_r;
  mpr_pkg::entry_t push_data, pop_data;
  logic            q_full, q_push, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pickup_mode: mpr_pkg::MODE_OMNI,
                 mic_pos_x:   '0,
                 mic_pos_y:   '0,
                 mic_pos_z:   '0,
                 facing_x:    '0,
                 facing_y:    '0,
                 facing_z:    mpr_pkg::FACE_Z_RST,
                 inv_speed:   mpr_pkg::INV_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpr_pkg::REG_MODE:   cfg_r.pickup_mode <= cfg_wdata[mpr_pkg::MODE_W-1:0];
        mpr_pkg::REG_MIC_X:  cfg_r.mic_pos_x   <= $signed(cfg_wdata);
        mpr_pkg::REG_MIC_Y:  cfg_r.mic_pos_y   <= $signed(cfg_wdata);
        mpr_pkg::REG_MIC_Z:  cfg_r.mic_pos_z   <= $signed(cfg_wdata);
        mpr_pkg::REG_FACE_X: cfg_r.facing_x    <= $signed(cfg_wdata[mpr_pkg::FACE_W-1:0]);
        mpr_pkg::REG_FACE_Y: cfg_r.facing_y    <= $signed(cfg_wdata[mpr_pkg::FACE_W-1:0]);
        mpr_pkg::REG_FACE_Z: cfg_r.facing_z    <= $signed(cfg_wdata[mpr_pkg::FACE_W-1:0]);
        mpr_pkg::REG_INV:    cfg_r.inv_speed   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mpr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_src_x (in_src_x),
    .in_src_y (in_src_y),
    .in_src_z (in_src_z),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  mpr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_data)
  );

  mpr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_data            (pop_data),
    .q_pop             (q_pop),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_delay         (out_delay),
    .out_amplitude     (out_amplitude),
    .out_zero_distance (out_zero_distance),
    .out_saturated     (out_saturated)
  );

  a_zero_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_distance) |->
      (out_delay == '0 && out_amplitude == '0 && !out_saturated))
    else $error("zero distance item carries nonzero results");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_delay == 32'hFFFF_FFFF || out_amplitude == 32'sh7FFF_FFFF ||
       out_amplitude == 32'sh8000_0000))
    else $error("saturated flag without a clipped result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

// ===== test/mic_pickup_response_unit_test.sv =====
// Self-checking testbench for the microphone pickup response block with random and directed items.
module mic_pickup_response_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mpr_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [mpr_pkg::DELAY_W-1:0]      delay;
    logic signed [mpr_pkg::AMP_W-1:0] amplitude;
    logic                             zero_distance;
    logic                             saturated;
  } result_item_t;

  class response_scoreboard;
    logic [mpr_pkg::MODE_W-1:0]        mode;
    logic signed [mpr_pkg::POS_W-1:0]  mic [3];
    logic signed [mpr_pkg::FACE_W-1:0] face [3];
    logic [mpr_pkg::INV_W-1:0]         inv_speed;
    result_item_t                      expected_q [$];
    int                                errors;
    int                                checked;

    function new();
      mode = mpr_pkg::MODE_OMNI;
      mic[0] = '0; mic[1] = '0; mic[2] = '0;
      face[0] = '0; face[1] = '0; face[2] = mpr_pkg::FACE_Z_RST;
      inv_speed = mpr_pkg::INV_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [mpr_pkg::CFG_IDX_W-1:0] idx,
                          logic [mpr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mpr_pkg::REG_MODE:   mode = data[mpr_pkg::MODE_W-1:0];
        mpr_pkg::REG_MIC_X:  mic[0] = data;
        mpr_pkg::REG_MIC_Y:  mic[1] = data;
        mpr_pkg::REG_MIC_Z:  mic[2] = data;
        mpr_pkg::REG_FACE_X: face[0] = data[mpr_pkg::FACE_W-1:0];
        mpr_pkg::REG_FACE_Y: face[1] = data[mpr_pkg::FACE_W-1:0];
        mpr_pkg::REG_FACE_Z: face[2] = data[mpr_pkg::FACE_W-1:0];
        mpr_pkg::REG_INV:    inv_speed = data;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_input(logic signed [mpr_pkg::POS_W-1:0] sx,
                             logic signed [mpr_pkg::POS_W-1:0] sy,
                             logic signed [mpr_pkg::POS_W-1:0] sz);
      longint          d [3];
      longint          dot;
      longint          k;
      longint          f;
      longint unsigned r2, r, dly, a, dmag, kmag, fmag, amag, m;
      bit              sat, neg;
      int              sh;
      result_item_t    res;
      d[0] = longint'(sx) - longint'(mic[0]);
      d[1] = longint'(sy) - longint'(mic[1]);
      d[2] = longint'(sz) - longint'(mic[2]);
      r2 = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        m = (d[i] < 0) ? -d[i] : d[i];
        r2 += m * m;
        dot += longint'(face[i]) * d[i];
      end
      sat = 0;
      neg = 0;
      if (r2 == 0) begin
        res.delay = '0;
        res.amplitude = '0;
        res.zero_distance = 1'b1;
        res.saturated = 1'b0;
      end else begin
        r = int_sqrt(r2 << 12);
        dly = (r * inv_speed) >> 14;
        if (dly > 64'hFFFF_FFFF) begin
          dly = 64'hFFFF_FFFF;
          sat = 1;
        end
        a = (64'd1 << 48) / r2;
        if (mode == mpr_pkg::MODE_FIG8 || mode == mpr_pkg::MODE_CARD) begin
          dmag = (dot < 0) ? -dot : dot;
          kmag = (dmag << 6) / r;
          if (kmag > 64'd131072) kmag = 64'd131072;
          k = (dot < 0) ? -longint'(kmag) : longint'(kmag);
          if (mode == mpr_pkg::MODE_FIG8) begin
            f = k;
            sh = 14;
          end else begin
            f = k + 16384;
            sh = 15;
          end
          neg = f < 0;
          fmag = neg ? -f : f;
          if (a > (64'd1 << 46)) a = 64'd1 << 46;
          amag = (a * fmag) >> sh;
        end else begin
          amag = a;
        end
        if (neg) begin
          if (amag > 64'h8000_0000) begin
            amag = 64'h8000_0000;
            sat = 1;
          end
          res.amplitude = 32'(-amag);
        end else begin
          if (amag > 64'h7FFF_FFFF) begin
            amag = 64'h7FFF_FFFF;
            sat = 1;
          end
          res.amplitude = 32'(amag);
        end
        res.delay = 32'(dly);
        res.zero_distance = 1'b0;
        res.saturated = sat;
      end
      expected_q.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
    endtask

    task check_result(result_item_t got);
      result_item_t want;
      if (expected_q.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.delay !== want.delay) report("delay", got.delay, want.delay);
        if (got.amplitude !== want.amplitude)
          report("amplitude", 32'(got.amplitude), 32'(want.amplitude));
        if (got.zero_distance !== want.zero_distance)
          report("zero_distance", got.zero_distance, want.zero_distance);
        if (got.saturated !== want.saturated)
          report("saturated", got.saturated, want.saturated);
      end
      checked++;
    endtask
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 240;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [mpr_pkg::POS_W-1:0]   in_src_x;
  logic signed [mpr_pkg::POS_W-1:0]   in_src_y;
  logic signed [mpr_pkg::POS_W-1:0]   in_src_z;
  logic                               out_valid;
  logic                               out_ready;
  logic [mpr_pkg::DELAY_W-1:0]        out_delay;
  logic signed [mpr_pkg::AMP_W-1:0]   out_amplitude;
  logic                               out_zero_distance;
  logic                               out_saturated;
  logic                               cfg_we;
  logic [mpr_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [mpr_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  response_scoreboard        sb;
  bit                        calm;
  int                        cycles;
  int                        items_sent;

  mic_pickup_response_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_src_x(in_src_x), .in_src_y(in_src_y), .in_src_z(in_src_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_delay(out_delay), .out_amplitude(out_amplitude),
    .out_zero_distance(out_zero_distance), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_item_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("mic_pickup_response_unit_test: FAIL");
      $finish;
    end
    out_ready <= calm || ($urandom_range(99) >= 23);
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_src_x, in_src_y, in_src_z);
      if (out_valid && out_ready) begin
        got.delay = out_delay;
        got.amplitude = out_amplitude;
        got.zero_distance = out_zero_distance;
        got.saturated = out_saturated;
        sb.check_result(got);
      end
    end
  end

  task write_reg(logic [mpr_pkg::CFG_IDX_W-1:0] idx, logic [mpr_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task send_position(logic signed [mpr_pkg::POS_W-1:0] sx,
                     logic signed [mpr_pkg::POS_W-1:0] sy,
                     logic signed [mpr_pkg::POS_W-1:0] sz);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_x <= sx;
    in_src_y <= sy;
    in_src_z <= sz;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function logic signed [mpr_pkg::POS_W-1:0] pick_coord(logic signed [mpr_pkg::POS_W-1:0] base,
                                                         int kind);
    int span;
    span = 1 << $urandom_range(14);
    case (kind)
      0: return base;
      1: return base + mpr_pkg::POS_W'($urandom_range(2 * span) - span);
      2: return base + mpr_pkg::POS_W'($urandom_range(2 * 4194304) - 4194304);
      default: return mpr_pkg::POS_W'($urandom);
    endcase
  endfunction

  task send_random;
    int pct;
    int kind;
    pct = $urandom_range(99);
    kind = (pct < 8) ? 0 : (pct < 50) ? 1 : (pct < 80) ? 2 : 3;
    send_position(pick_coord(sb.mic[0], kind), pick_coord(sb.mic[1], kind),
                  pick_coord(sb.mic[2], kind));
  endtask

  task wait_idle;
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task configure_phase(int p);
    case (p)
      1: begin
        write_reg(mpr_pkg::REG_MODE, mpr_pkg::CFG_DATA_W'(mpr_pkg::MODE_FIG8));
        write_reg(mpr_pkg::REG_FACE_X, 24'd16384);
        write_reg(mpr_pkg::REG_FACE_Z, 24'd0);
        write_reg(mpr_pkg::REG_INV, 24'hFFFFFF);
      end
      2: begin
        write_reg(mpr_pkg::REG_MODE, mpr_pkg::CFG_DATA_W'(mpr_pkg::MODE_CARD));
        write_reg(mpr_pkg::REG_MIC_X, 24'h7FFFFF);
        write_reg(mpr_pkg::REG_MIC_Y, 24'h800000);
        write_reg(mpr_pkg::REG_MIC_Z, 24'd12345);
        write_reg(mpr_pkg::REG_FACE_X, 24'd0);
        write_reg(mpr_pkg::REG_FACE_Y, 24'(-16384));
        write_reg(mpr_pkg::REG_INV, 24'd48913);
      end
      3: begin
        write_reg(mpr_pkg::REG_MODE, mpr_pkg::CFG_DATA_W'(MODE_SPARE));
        write_reg(mpr_pkg::REG_MIC_X, 24'($urandom));
        write_reg(mpr_pkg::REG_MIC_Y, 24'($urandom));
        write_reg(mpr_pkg::REG_MIC_Z, 24'($urandom));
        write_reg(mpr_pkg::REG_FACE_Y, 24'd0);
        write_reg(mpr_pkg::REG_FACE_Z, 24'(-16384));
        write_reg(mpr_pkg::REG_INV, 24'd0);
      end
      4: begin
        write_reg(mpr_pkg::REG_MODE, mpr_pkg::CFG_DATA_W'(mpr_pkg::MODE_FIG8));
        write_reg(mpr_pkg::REG_MIC_X, 24'h800000);
        write_reg(mpr_pkg::REG_MIC_Y, 24'h800000);
        write_reg(mpr_pkg::REG_MIC_Z, 24'h800000);
        write_reg(mpr_pkg::REG_FACE_X, 24'h7FFF);
        write_reg(mpr_pkg::REG_FACE_Y, 24'h8000);
        write_reg(mpr_pkg::REG_FACE_Z, 24'h7FFF);
        write_reg(mpr_pkg::REG_INV, 24'($urandom));
      end
      5: begin
        write_reg(mpr_pkg::REG_MODE, mpr_pkg::CFG_DATA_W'(mpr_pkg::MODE_CARD));
        write_reg(mpr_pkg::REG_MIC_X, 24'($urandom));
        write_reg(mpr_pkg::REG_MIC_Y, 24'($urandom));
        write_reg(mpr_pkg::REG_MIC_Z, 24'($urandom));
        write_reg(mpr_pkg::REG_FACE_X, 24'($urandom));
        write_reg(mpr_pkg::REG_FACE_Y, 24'($urandom));
        write_reg(mpr_pkg::REG_FACE_Z, 24'($urandom));
      end
      6: begin
        write_reg(mpr_pkg::REG_MIC_X, 24'd0);
        write_reg(mpr_pkg::REG_MIC_Y, 24'd0);
        write_reg(mpr_pkg::REG_MIC_Z, 24'd0);
        write_reg(mpr_pkg::REG_FACE_X, 24'd11585);
        write_reg(mpr_pkg::REG_FACE_Y, 24'd11585);
        write_reg(mpr_pkg::REG_FACE_Z, 24'd0);
        write_reg(mpr_pkg::REG_INV, 24'd48913);
      end
      7: begin
        write_reg(mpr_pkg::REG_MODE, mpr_pkg::CFG_DATA_W'(mpr_pkg::MODE_OMNI));
        write_reg(mpr_pkg::REG_MIC_X, 24'($urandom));
        write_reg(mpr_pkg::REG_MIC_Z, 24'($urandom));
        write_reg(mpr_pkg::REG_INV, 24'($urandom));
      end
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task send_directed(int p);
    logic signed [mpr_pkg::POS_W-1:0] mx, my, mz;
    mx = sb.mic[0];
    my = sb.mic[1];
    mz = sb.mic[2];
    send_position(mx, my, mz);
    send_position(mx + 24'd1, my, mz);
    send_position(mx, my, mz + 24'd65536);
    send_position(mx, my, mz - 24'd65536);
    if (p == 0) begin
      send_position(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_position(24'h800000, 24'h800000, 24'h800000);
      send_position(24'h7FFFFF, 24'h800000, 24'd0);
      send_position(24'd0, 24'd1, 24'd0);
      send_position(24'd0, 24'd0, 24'h800000);
      send_position(24'd65536, 24'd0, 24'd0);
      send_position(24'd0, 24'hFFFFFF, 24'd0);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_src_x = '0;
    in_src_y = '0;
    in_src_z = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    cycles = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      send_directed(p);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = (p == 5) && (i >= 60) && (i < 180);
        send_random();
      end
      calm = 1'b0;
      wait_idle();
    end
    $display("Sent %0d source positions over %0d register settings, all pickup modes.",
             items_sent, PHASES);
    $display("Checked %0d responses with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("mic_pickup_response_unit_test: PASS");
    end else begin
      $display("mic_pickup_response_unit_test: FAIL");
    end
    $finish;
  end
endmodule
